/* src/aes_pkg.sv */
// AES-128 package: shared types, S-box tables and GF(2^8) helpers.
// Used by the round cell, key cell and top level; no dependencies.
package aes_pkg;

  localparam int RoundCount = 10;
  localparam int KeyWords   = 4;
  localparam int TotalWords = 4 * (RoundCount + 1);

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;

  // Request travelling down the round chain
  typedef struct packed {
    logic vld;
    logic dec;
    blk_t data;
  } stage_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Byte n of a block sits at bits 127-8n .. 120-8n
  function automatic logic [7:0] bget(input blk_t b, input int n);
    bget = b[127 - 8 * n -: 8];
  endfunction

  function automatic word_t sub_word(input word_t w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

/* src/aes_key_cell.sv */
// AES key schedule cell: derives the next 4-word round key from the previous one.
// Depends on aes_pkg.
module aes_key_cell (
  input  aes_pkg::blk_t         prev_key,
  input  logic [7:0]            rcon,
  output aes_pkg::blk_t         next_key
);
  import aes_pkg::*;

  word_t w0, w1, w2, w3, t;

  // Rotate, substitute and fold in the round constant
  always_comb begin
    t  = sub_word({prev_key[23:0], prev_key[31:24]}) ^ {rcon, 24'h0};
    w0 = prev_key[127:96] ^ t;
    w1 = prev_key[95:64] ^ w0;
    w2 = prev_key[63:32] ^ w1;
    w3 = prev_key[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  end

endmodule

/* src/aes_round_cell.sv */
// AES round cell: one registered round, encrypt or decrypt, selected per request.
// Depends on aes_pkg.
module aes_round_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                is_last,
  input  aes_pkg::blk_t       enc_key,
  input  aes_pkg::blk_t       dec_key,
  input  aes_pkg::stage_t     stg_in,
  output aes_pkg::stage_t     stg_out
);
  import aes_pkg::*;

  logic   vld_r;
  logic   dec_r;
  blk_t   data_r;
  blk_t   enc_v, dec_v, sb, sr, mc, isr, isb, ark, imc;

  // Forward round: SubBytes, ShiftRows, MixColumns, AddRoundKey (MixColumns skipped in the last round)
  always_comb begin
    for (int n = 0; n < 16; n++) sb[127 - 8 * n -: 8] = SBOX[bget(stg_in.data, n)];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr[127 - 8 * (4 * c + r) -: 8] = bget(sb, 4 * ((c + r) % 4) + r);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        mc[127 - 8 * (4 * c + r) -: 8] =
          xt(bget(sr, 4 * c + r)) ^ xt(bget(sr, 4 * c + (r + 1) % 4))
          ^ bget(sr, 4 * c + (r + 1) % 4) ^ bget(sr, 4 * c + (r + 2) % 4)
          ^ bget(sr, 4 * c + (r + 3) % 4);
    enc_v = (is_last ? sr : mc) ^ enc_key;
  end

  // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (InvMixColumns skipped in the last round)
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        isr[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = bget(stg_in.data, 4 * c + r);
    for (int n = 0; n < 16; n++) isb[127 - 8 * n -: 8] = ISBOX[bget(isr, n)];
    ark = isb ^ dec_key;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        imc[127 - 8 * (4 * c + r) -: 8] =
          gmul(8'h0e, bget(ark, 4 * c + r)) ^ gmul(8'h0b, bget(ark, 4 * c + (r + 1) % 4))
          ^ gmul(8'h0d, bget(ark, 4 * c + (r + 2) % 4))
          ^ gmul(8'h09, bget(ark, 4 * c + (r + 3) % 4));
    dec_v = is_last ? ark : imc;
  end

  // Advance the request to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= stg_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r  <= stg_in.dec;
      data_r <= stg_in.dec ? dec_v : enc_v;
    end
  end

  assign stg_out = {vld_r, dec_r, data_r};

endmodule

/* src/aes128_block_cipher.sv */
// AES-128 ECB block cipher top level: key schedule and a chain of ten round cells.
// Depends on aes_pkg, aes_key_cell and aes_round_cell.
//
// Usage: write key_high (index 0) and key_low (index 1) on the cfg_ channel
// while idle. Each write restarts the key schedule, which loads the key and
// then builds one round key per cycle; in_ready stays low until it is done,
// including after reset with the all-zero key. Then send requests on in_
// (opcode 0 encrypts, 1 decrypts). The block takes one request per cycle,
// and the result appears on out_ after one input register for the initial
// AddRoundKey, then one register per round cell. When a finished result
// waits on a stalled receiver, the whole chain holds and in_ready drops,
// bubbles included; otherwise the input takes a request every cycle. Reset
// clears all valid flags and the key-ready flag.
module aes128_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        keys_ready_r;
  logic [3:0]  kcnt_r;
  logic [7:0]  rcon_r;
  blk_t        rk_r [RoundCount + 1];
  blk_t        kcur_r;
  blk_t        knext;
  stage_t      chain [RoundCount + 1];
  logic        entry_vld_r;
  logic        entry_dec_r;
  blk_t        entry_data_r;
  logic        adv;
  logic        hole;

  assign cfg_ready = 1'b1;

  // Hold the key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        default:      ;
      endcase
    end
  end

  aes_key_cell u_key (.prev_key(kcur_r), .rcon(rcon_r), .next_key(knext));

  // Step the key schedule one round key per cycle
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_valid) begin
      keys_ready_r <= 1'b0;
      kcnt_r       <= '0;
    end else if (!keys_ready_r) begin
      kcnt_r <= kcnt_r + 4'd1;
      if (kcnt_r == 4'(RoundCount)) keys_ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!keys_ready_r) begin
      if (kcnt_r == 4'd0) begin
        kcur_r    <= {key_high_r, key_low_r};
        rk_r[0]   <= {key_high_r, key_low_r};
        rcon_r    <= 8'h01;
      end else begin
        kcur_r       <= knext;
        rk_r[kcnt_r] <= knext;
        rcon_r       <= xt(rcon_r);
      end
    end
  end

  // Stall the chain only when a finished result waits and nothing can move
  assign hole      = !chain[RoundCount].vld;
  assign adv       = out_ready || hole;
  assign in_ready  = keys_ready_r && adv;

  // Entry register: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
    end else if (adv) begin
      entry_vld_r <= in_valid && keys_ready_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_dec_r  <= in_opcode;
      entry_data_r <= {in_block_high, in_block_low}
                      ^ (in_opcode ? rk_r[RoundCount] : rk_r[0]);
    end
  end

  assign chain[0] = {entry_vld_r, entry_dec_r, entry_data_r};

  // Round cells; decrypt walks the round keys backwards
  for (genvar g = 1; g <= RoundCount; g++) begin : g_round
    aes_round_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .is_last (g == RoundCount),
      .enc_key (rk_r[g]),
      .dec_key (rk_r[RoundCount - g]),
      .stg_in  (chain[g - 1]),
      .stg_out (chain[g])
    );
  end

  assign out_valid       = chain[RoundCount].vld;
  assign out_result_high = chain[RoundCount].data[127:64];
  assign out_result_low  = chain[RoundCount].data[63:0];

endmodule

/* verif/aes128_block_cipher_test.sv */
// Self-checking testbench for the AES-128 ECB block cipher top level.
// Depends on aes_pkg and aes128_block_cipher; predicts ciphertext/plaintext per request.
`timescale 1ns / 100ps

module aes128_block_cipher_test;
  import aes_pkg::*;

  typedef struct {
    op_t         op;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_req_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  aes128_block_cipher dut (.*);

  // predictor state
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [31:0] rk [44];
  logic [7:0]  sb_tab [256];
  logic [7:0]  isb_tab [256];

  blk_req_t pending_reqs [$];
  blk_res_t expected_blocks [$];
  int       errors;
  int       results_seen;
  int       blocks_sent;
  int       keys_used;
  bit       noisy_in;
  bit       noisy_out;
  bit       hold_out;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // GF(2^8) helpers for the predictor
  function automatic logic [7:0] gf2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = gf2(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Build S-box tables from the field inverse and the affine map
  task automatic build_sboxes();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gfm(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
      sb_tab[x] = s;
      isb_tab[s] = x[7:0];
    end
  endtask

  task automatic expand_round_keys();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    rk[0] = key_hi_q[63:32];
    rk[1] = key_hi_q[31:0];
    rk[2] = key_lo_q[63:32];
    rk[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = rk[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb_tab[t[31:24]] ^ rc, sb_tab[t[23:16]], sb_tab[t[15:8]], sb_tab[t[7:0]]};
        rc = gf2(rc);
      end
      rk[i] = rk[i-4] ^ t;
    end
  endtask

  function automatic blk_res_t aes_transform(input blk_req_t r);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] a [4];
    logic [7:0] m [4];
    bit dec;
    blk_res_t res;
    int rnd;
    dec = (r.op == OP_DECRYPT);
    for (int i = 0; i < 8; i++) begin
      s[i]   = r.hi[63-8*i -: 8];
      s[i+8] = r.lo[63-8*i -: 8];
    end
    if (dec) begin
      m[0] = 8'h0e;
      m[1] = 8'h0b;
      m[2] = 8'h0d;
      m[3] = 8'h09;
    end else begin
      m[0] = 8'h02;
      m[1] = 8'h03;
      m[2] = 8'h01;
      m[3] = 8'h01;
    end
    for (int step = 0; step <= 10; step++) begin
      rnd = dec ? 10 - step : step;
      if (step > 0) begin
        // shift rows, then substitute
        o = s;
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++)
            if (dec) s[4*((c+rw)%4)+rw] = o[4*c+rw];
            else s[4*c+rw] = o[4*((c+rw)%4)+rw];
        for (int i = 0; i < 16; i++) s[i] = dec ? isb_tab[s[i]] : sb_tab[s[i]];
        // forward mix happens before the round key
        if (!dec && step < 10)
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
            for (int k = 0; k < 4; k++)
              s[4*c+k] = gfm(m[0], a[k]) ^ gfm(m[1], a[(k+1)%4])
                       ^ gfm(m[2], a[(k+2)%4]) ^ gfm(m[3], a[(k+3)%4]);
          end
      end
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) s[4*c+k] ^= rk[4*rnd+c][31-8*k -: 8];
      // inverse mix comes after the round key
      if (dec && step > 0 && step < 10)
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
          for (int k = 0; k < 4; k++)
            s[4*c+k] = gfm(m[0], a[k]) ^ gfm(m[1], a[(k+1)%4])
                     ^ gfm(m[2], a[(k+2)%4]) ^ gfm(m[3], a[(k+3)%4]);
        end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[i+8];
    end
    return res;
  endfunction

  // Driver: present queued requests, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_blocks.push_back(aes_transform(pending_reqs.pop_front()));
        blocks_sent++;
      end
      if (pending_reqs.size() > 0 &&
          !(noisy_in && $urandom_range(99) < 13)) begin
        in_valid      <= 1'b1;
        in_opcode     <= pending_reqs[0].op;
        in_block_high <= pending_reqs[0].hi;
        in_block_low  <= pending_reqs[0].lo;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random or for a long hold
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_out && !(noisy_out && $urandom_range(99) < 13);
  end

  // Monitor: compare each result with the oldest expected block
  always @(posedge clk) begin
    blk_res_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_blocks.size() == 0) begin
        $error("unexpected result %h_%h", out_result_high, out_result_low);
        errors++;
      end else begin
        e = expected_blocks.pop_front();
        if (out_result_high !== e.hi) begin
          $error("result_high expected %h actual %h", e.hi, out_result_high);
          errors++;
        end
        if (out_result_low !== e.lo) begin
          $error("result_low expected %h actual %h", e.lo, out_result_low);
          errors++;
        end
      end
    end
  end

  task automatic write_key(input cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
  endtask

  task automatic queue_block(input op_t op, input logic [63:0] hi, input logic [63:0] lo);
    blk_req_t r;
    r.op = op;
    r.hi = hi;
    r.lo = lo;
    pending_reqs.push_back(r);
  endtask

  // Let every queued request through and every result arrive
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    write_key(CFG_KEY_HIGH, hi);
    write_key(CFG_KEY_LOW, lo);
    expand_round_keys();
    keys_used++;
  endtask

  // Random blocks with a random encrypt/decrypt mix
  task automatic random_blocks(input int n);
    for (int i = 0; i < n; i++)
      queue_block(op_t'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_block_high = '0;
    in_block_low = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    errors = 0;
    results_seen = 0;
    blocks_sent = 0;
    keys_used = 1;
    noisy_in = 1'b0;
    noisy_out = 1'b0;
    hold_out = 1'b0;
    key_hi_q = '0;
    key_lo_q = '0;
    build_sboxes();
    expand_round_keys();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // All-zero key straight after reset, extreme blocks, both operations
    queue_block(OP_ENCRYPT, '0, '0);
    queue_block(OP_DECRYPT, '0, '0);
    queue_block(OP_ENCRYPT, '1, '1);
    queue_block(OP_DECRYPT, '1, '1);
    drain();

    // Standard test vector key, then extreme keys
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    queue_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    queue_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    queue_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    queue_block(OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    set_key('1, '1);
    queue_block(OP_ENCRYPT, '0, '1);
    queue_block(OP_DECRYPT, '1, '0);
    drain();
    // Single-register write still forces a new schedule
    write_key(CFG_KEY_LOW, 64'h0);
    expand_round_keys();
    queue_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    queue_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();

    // Back-to-back random, no idling
    set_key({$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(300);
    drain();

    // Long receiver hold while the sender keeps offering
    random_blocks(100);
    hold_out = 1'b1;
    repeat (200) @(posedge clk);
    hold_out = 1'b0;
    drain();

    // Random idling on both sides under several keys
    noisy_in = 1'b1;
    noisy_out = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      random_blocks(230);
      drain();
    end
    set_key('0, '0);
    random_blocks(20);
    drain();

    $display("Covered %0d blocks under %0d keys, %0d results checked.",
             blocks_sent, keys_used, results_seen);
    if (errors == 0 && expected_blocks.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
src/aes_pkg.sv
src/aes_key_cell.sv
src/aes_round_cell.sv
src/aes128_block_cipher.sv
verif/aes128_block_cipher_test.sv
